// ----- sv/sirs_pkg.sv -----
`default_nettype none

package sirs_pkg;

    localparam int SYM_W       = 8;
    localparam int BASE_W      = 6;
    localparam int REM_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ALPHA_WORDS = 4;
    localparam int ALPHA_LIMIT = 32;
    localparam int DIV_STEPS   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_3 = 3'd4;

    localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;

    localparam logic [BASE_W-1:0]     BASE_SIZE_RST     = 6'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOL_WORD_0_RST = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] SYMBOL_WORD_1_RST = 64'h0000000000003938;
    localparam logic [CFG_DATA_W-1:0] SYMBOL_WORD_2_RST = 64'h0;
    localparam logic [CFG_DATA_W-1:0] SYMBOL_WORD_3_RST = 64'h0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic busy;
        logic ok;
    } base_stat_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic out_sign;
        logic out_zero;
        logic out_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic pass_end;
        logic quo_next_zero;
        logic neg;
        logic cnt_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/sirs_cfg.sv -----
`default_nettype none

module sirs_cfg #(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [sirs_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [sirs_pkg::CFG_DATA_W-1:0]             cfg_data,
    output logic [sirs_pkg::BASE_W-1:0]                      base_size,
    output logic [MAX_SYMBOLS-1:0][sirs_pkg::SYM_W-1:0]      syms,
    output sirs_pkg::base_stat_t                             base_stat
);
    import sirs_pkg::*;

    localparam int CW = $clog2(MAX_SYMBOLS);

    logic [BASE_W-1:0]     base_size_reg;
    logic [CFG_DATA_W-1:0] word_reg [ALPHA_WORDS];
    logic                  chk_busy_reg;
    logic                  chk_ok_reg;
    logic [CW-1:0]         chk_idx_reg;

    logic             cfg_wr;
    logic [SYM_W-1:0] sym_i;
    logic             dup;
    logic             range_bad;
    logic             sym_bad;
    logic             last_pos;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= BASE_SIZE_RST;
            word_reg[0]   <= SYMBOL_WORD_0_RST;
            word_reg[1]   <= SYMBOL_WORD_1_RST;
            word_reg[2]   <= SYMBOL_WORD_2_RST;
            word_reg[3]   <= SYMBOL_WORD_3_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_BASE_SIZE:     base_size_reg <= cfg_data[BASE_W-1:0];
                REG_SYMBOL_WORD_0: word_reg[0]   <= cfg_data;
                REG_SYMBOL_WORD_1: word_reg[1]   <= cfg_data;
                REG_SYMBOL_WORD_2: word_reg[2]   <= cfg_data;
                REG_SYMBOL_WORD_3: word_reg[3]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // positions past the register file read as byte 0
    for (genvar k = 0; k < MAX_SYMBOLS; k++)
    begin : g_sym
        if (k < ALPHA_LIMIT)
        begin : g_word
            assign syms[k] = word_reg[k/8][8*(k%8) +: 8];
        end
        else
        begin : g_zero
            assign syms[k] = '0;
        end
    end

    assign base_size = base_size_reg;

    // one alphabet position per cycle against all later positions in use
    always_comb
    begin
        sym_i     = syms[chk_idx_reg];
        range_bad = (base_size_reg < 6'd2) || (7'(base_size_reg) > 7'(MAX_SYMBOLS));
        sym_bad   = (sym_i == MINUS_SYM) || (sym_i == PLUS_SYM);
        last_pos  = (7'(chk_idx_reg) + 7'd1) == 7'(base_size_reg);
        dup       = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((j > int'(chk_idx_reg)) && (j < int'(base_size_reg)) && (syms[j] == sym_i))
                dup = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_busy_reg <= 1'b1;
            chk_ok_reg   <= 1'b0;
            chk_idx_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            chk_busy_reg <= 1'b1;
            chk_ok_reg   <= 1'b0;
            chk_idx_reg  <= '0;
        end
        else if (chk_busy_reg)
        begin
            if (range_bad || sym_bad || dup)
            begin
                chk_busy_reg <= 1'b0;
                chk_ok_reg   <= 1'b0;
            end
            else if (last_pos)
            begin
                chk_busy_reg <= 1'b0;
                chk_ok_reg   <= 1'b1;
            end
            else
            begin
                chk_idx_reg <= chk_idx_reg + CW'(1);
            end
        end
    end

    assign base_stat.busy = chk_busy_reg;
    assign base_stat.ok   = chk_ok_reg;

endmodule

`default_nettype wire

// ----- sv/sirs_dp.sv -----
`default_nettype none

module sirs_dp #(
    parameter int MAX_SYMBOLS  = 32,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic signed [NUMBER_WIDTH-1:0]              number,
    input  wire logic [sirs_pkg::BASE_W-1:0]                 base_size,
    input  wire logic [MAX_SYMBOLS-1:0][sirs_pkg::SYM_W-1:0] syms,
    input  wire sirs_pkg::dp_cmd_t                           cmd,
    output sirs_pkg::dp_stat_t                               stat,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic [sirs_pkg::SYM_W-1:0]                       symbol,
    output logic                                             last
);
    import sirs_pkg::*;

    localparam int NW        = NUMBER_WIDTH;
    localparam int NWP       = ((NW + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int PASS_CYC  = NWP / DIV_STEPS;
    localparam int PCW       = $clog2(PASS_CYC + 1);
    localparam int CNTW      = $clog2(NW + 1);
    localparam int AW        = $clog2(NW);
    localparam int DW        = $clog2(MAX_SYMBOLS);
    localparam logic [PCW-1:0] PASS_LAST = PCW'(PASS_CYC - 1);

    logic [NWP-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [PCW-1:0]   pass_cnt_reg, pass_cnt_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DW-1:0]    rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;

    logic [DW-1:0]    stack_mem [NW];

    logic [NW-1:0]    num_u;
    logic [NW-1:0]    mag;
    logic [NWP-1:0]   quo_step;
    logic [REM_W-1:0] rem_step;
    logic             pass_end;
    logic             push;
    logic             out_load;

    assign num_u    = number;
    assign mag      = num_u[NW-1] ? (~num_u + 1'b1) : num_u;
    assign pass_end = (pass_cnt_reg == '0);
    assign push     = cmd.div_step & pass_end;
    assign out_load = cmd.out_sign | cmd.out_zero | cmd.out_digit;

    // restoring divider, eight quotient bits per cycle
    always_comb
    begin
        logic [NWP-1:0]   q;
        logic [REM_W-1:0] r;
        logic [REM_W:0]   t;
        q = quo_reg;
        r = rem_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            t = {r, q[NWP-1]};
            if (t >= {1'b0, base_size})
            begin
                r = REM_W'(t - {1'b0, base_size});
                q = {q[NWP-2:0], 1'b1};
            end
            else
            begin
                r = t[REM_W-1:0];
                q = {q[NWP-2:0], 1'b0};
            end
        end
        quo_step = q;
        rem_step = r;
    end

    always_comb
    begin
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        pass_cnt_next  = pass_cnt_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg & out_stall;
        sym_next       = sym_reg;
        last_next      = last_reg;

        if (cmd.load)
        begin
            quo_next      = NWP'(mag);
            rem_next      = '0;
            pass_cnt_next = PASS_LAST;
            cnt_next      = '0;
            neg_next      = num_u[NW-1];
        end
        else if (cmd.div_step)
        begin
            quo_next = quo_step;
            if (pass_end)
            begin
                rem_next      = '0;
                pass_cnt_next = PASS_LAST;
                cnt_next      = cnt_reg + CNTW'(1);
            end
            else
            begin
                rem_next      = rem_step;
                pass_cnt_next = pass_cnt_reg - PCW'(1);
            end
        end
        else if (cmd.rd)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end

        if (cmd.out_sign)
        begin
            sym_next  = MINUS_SYM;
            last_next = 1'b0;
        end
        else if (cmd.out_zero)
        begin
            sym_next  = syms[0];
            last_next = 1'b1;
        end
        else if (cmd.out_digit)
        begin
            sym_next  = syms[rd_data_reg];
            last_next = (cnt_reg == '0);
        end
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_cnt_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pass_cnt_reg  <= pass_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    // digit stack, least significant digit at the bottom
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[cnt_reg[AW-1:0]] <= rem_step[DW-1:0];
        if (cmd.rd)
            rd_data_reg <= stack_mem[AW'(cnt_reg - CNTW'(1))];
    end

    assign stat.in_zero       = (num_u == '0);
    assign stat.pass_end      = pass_end;
    assign stat.quo_next_zero = (quo_step == '0);
    assign stat.neg           = neg_reg;
    assign stat.cnt_zero      = (cnt_reg == '0);
    assign stat.out_free      = ~out_valid_reg | ~out_stall;

    assign out_valid = out_valid_reg;
    assign symbol    = sym_reg;
    assign last      = last_reg;

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> cnt_reg != '0)
        else $error("digit stack read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg < CNTW'(NW))
        else $error("digit stack overflow");

    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_digit |=> out_valid_reg && (last_reg == (cnt_reg == '0)))
        else $error("last flag does not match digit stack level");

endmodule

`default_nettype wire

// ----- sv/sirs_ctrl.sv -----
`default_nettype none

module sirs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire sirs_pkg::base_stat_t base_stat,
    input  wire sirs_pkg::dp_stat_t   dp_stat,
    output sirs_pkg::dp_cmd_t         cmd
);
    import sirs_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        accept     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = base_stat.busy;
                accept   = in_valid & ~base_stat.busy;
                // an item under a rejected alphabet is dropped
                if (accept && base_stat.ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = dp_stat.in_zero ? ST_ZERO : ST_DIV;
                end
            end
            ST_ZERO:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dp_stat.pass_end && dp_stat.quo_next_zero)
                    state_next = dp_stat.neg ? ST_SIGN : ST_READ;
            end
            ST_SIGN:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.out_digit = 1'b1;
                    state_next    = dp_stat.cnt_zero ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_sign || cmd.out_zero || cmd.out_digit) |-> dp_stat.out_free)
        else $error("output register overwritten");

    a_no_take_during_check: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !base_stat.busy && state_reg == ST_IDLE)
        else $error("item taken while busy or alphabet check running");

    a_load_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> base_stat.ok && !base_stat.busy)
        else $error("conversion started under a rejected alphabet");

endmodule

`default_nettype wire

// ----- sv/signed_int_to_radix_symbols_top.sv -----
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       sink       in_valid / in_stall      number
// out      source     out_valid / out_stall    symbol, last
// cfg      sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item: it is loaded, then each digit takes one pass through the restoring
// divider (8 quotient bits per cycle), then a minus sign is emitted when negative and
// each digit is read through the digit stack read port and then emitted. Zero emits
// the first alphabet symbol as its only symbol. Output stalls hold the output steps.
// After reset and after every register write the alphabet check walks one
// position per cycle; in_stall stays high meanwhile.
// Reset loads radix 10 with alphabet "0123456789".
// out_stall holds the output register; conversion waits for it, one item at a time.

module signed_int_to_radix_symbols_top #(
    parameter int MAX_SYMBOLS  = 32,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [NUMBER_WIDTH-1:0]    number,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [sirs_pkg::SYM_W-1:0]             symbol,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sirs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sirs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sirs_pkg::*;

    logic [BASE_W-1:0]                 base_size;
    logic [MAX_SYMBOLS-1:0][SYM_W-1:0] syms;
    base_stat_t                        base_stat;
    dp_cmd_t                           cmd;
    dp_stat_t                          dp_stat;

    sirs_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .base_size (base_size),
        .syms      (syms),
        .base_stat (base_stat)
    );

    sirs_dp #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .base_size (base_size),
        .syms      (syms),
        .cmd       (cmd),
        .stat      (dp_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last)
    );

    sirs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base_stat (base_stat),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

endmodule

`default_nettype wire
